/* sv/tcvf_pkg.sv */
`default_nettype none

package tcvf_pkg;

	localparam int LITERALS   = 64;
	localparam int STATE_BITS = 8;

	localparam int CMD_W  = 3;
	localparam int FEAT_W = 64;
	localparam int IDX_W  = 7;
	localparam int SLOT_W = 6;
	localparam int WVAL_W = 8;

	localparam longint STATE_MAX = (longint'(1) <<< (STATE_BITS - 1)) - longint'(1);
	localparam longint STATE_MIN = -STATE_MAX - longint'(1);
	localparam longint WVAL_MAX  = (longint'(1) <<< (WVAL_W - 1)) - longint'(1);
	localparam longint WVAL_MIN  = -WVAL_MAX - longint'(1);

	typedef logic signed [STATE_BITS-1:0] state_t;
	typedef logic signed [WVAL_W-1:0]     wval_t;
	typedef logic [FEAT_W-1:0]            feat_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [SLOT_W-1:0]            slot_t;

	localparam state_t ST_MAX = state_t'(STATE_MAX);
	localparam state_t ST_MIN = state_t'(STATE_MIN);

	typedef enum logic [CMD_W-1:0] {
		CMD_VOTE  = 3'd0,
		CMD_FB1   = 3'd1,
		CMD_FB2   = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic   accept;
		cmd_t   cmd;
		logic   last_vote;
		state_t wdata;
	} lane_ctrl_t;

	typedef struct packed {
		logic   violation;
		state_t pos;
		state_t neg;
	} lane_stat_t;

	function automatic state_t clamp_write(input wval_t w);
		longint v;
		begin
			v = longint'(w);
			if (v > STATE_MAX) v = STATE_MAX;
			if (v < STATE_MIN) v = STATE_MIN;
			return state_t'(v);
		end
	endfunction

	function automatic wval_t sat_read(input state_t s);
		longint v;
		begin
			v = longint'(s);
			if (v > WVAL_MAX) v = WVAL_MAX;
			if (v < WVAL_MIN) v = WVAL_MIN;
			return wval_t'(v);
		end
	endfunction

	function automatic state_t sat_inc(input state_t s);
		return (s == ST_MAX) ? s : state_t'(s + state_t'(1));
	endfunction

	function automatic state_t sat_dec(input state_t s);
		return (s == ST_MIN) ? s : state_t'(s - state_t'(1));
	endfunction

endpackage

`default_nettype wire

/* sv/tcvf_ifs.sv */
`default_nettype none

interface tcvf_in_if;
	import tcvf_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	feat_t features;
	feat_t radical_mask;
	feat_t conservative_mask;
	idx_t  literal_index;
	wval_t write_value;

	modport source (output valid, command, features, radical_mask, conservative_mask,
		literal_index, write_value, input ready);
	modport sink (input valid, command, features, radical_mask, conservative_mask,
		literal_index, write_value, output ready);
endinterface

interface tcvf_out_if;
	import tcvf_pkg::*;

	logic  valid;
	logic  ready;
	logic  clause_output;
	wval_t read_value;

	modport source (output valid, clause_output, read_value, input ready);
	modport sink (input valid, clause_output, read_value, output ready);
endinterface

`default_nettype wire

/* sv/tcvf_lane.sv */
`default_nettype none

module tcvf_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tcvf_pkg::lane_ctrl_t ctrl,
	input  wire logic                 feature,
	input  wire logic                 radical,
	input  wire logic                 conservative,
	input  wire logic                 wr_pos,
	input  wire logic                 wr_neg,
	output tcvf_pkg::lane_stat_t      stat
);
	import tcvf_pkg::*;

	state_t pos_q;
	state_t neg_q;
	logic   feat_q;
	logic   pos_excl_q;
	logic   neg_excl_q;

	logic   pos_inc;
	logic   neg_inc;
	logic   pos_up;
	logic   pos_dn;
	logic   neg_up;
	logic   neg_dn;
	state_t pos_d;
	state_t neg_d;

	assign pos_inc = ~pos_q[STATE_BITS-1];
	assign neg_inc = ~neg_q[STATE_BITS-1];

	always_comb begin
		pos_up = 1'b0;
		pos_dn = 1'b0;
		neg_up = 1'b0;
		neg_dn = 1'b0;
		case (ctrl.cmd)
			CMD_FB1: begin
				if (ctrl.last_vote) begin
					pos_up = feat_q & radical;
					pos_dn = ~feat_q & conservative;
					neg_dn = feat_q & conservative;
					neg_up = ~feat_q & radical;
				end else begin
					pos_dn = conservative;
					neg_dn = ~radical;
				end
			end
			CMD_FB2: begin
				if (ctrl.last_vote) begin
					pos_up = pos_excl_q & ~feat_q;
					neg_up = neg_excl_q & feat_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (wr_pos) pos_d = ctrl.wdata;
		else if (pos_up) pos_d = sat_inc(pos_q);
		else if (pos_dn) pos_d = sat_dec(pos_q);
		else pos_d = pos_q;

		if (wr_neg) neg_d = ctrl.wdata;
		else if (neg_up) neg_d = sat_inc(neg_q);
		else if (neg_dn) neg_d = sat_dec(neg_q);
		else neg_d = neg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			neg_q      <= '0;
			feat_q     <= 1'b0;
			pos_excl_q <= 1'b0;
			neg_excl_q <= 1'b0;
		end else if (ctrl.accept) begin
			pos_q <= pos_d;
			neg_q <= neg_d;
			if (ctrl.cmd == CMD_VOTE) begin
				feat_q     <= feature;
				pos_excl_q <= ~pos_inc;
				neg_excl_q <= ~neg_inc;
			end
		end
	end

	// included literal that is false under the incoming features
	assign stat.violation = (pos_inc & ~feature) | (neg_inc & feature);
	assign stat.pos       = pos_q;
	assign stat.neg       = neg_q;

endmodule

`default_nettype wire

/* sv/tcvf_merge.sv */
`default_nettype none

module tcvf_merge (
	input  wire tcvf_pkg::lane_stat_t stat [tcvf_pkg::LITERALS],
	input  wire tcvf_pkg::slot_t      slot,
	input  wire logic                 neg_bank,
	output logic                      vote,
	output tcvf_pkg::wval_t           rd_value
);
	import tcvf_pkg::*;

	state_t sel;

	always_comb begin
		vote = 1'b1;
		sel  = '0;
		for (int i = 0; i < LITERALS; i++) begin
			if (stat[i].violation) vote = 1'b0;
			if (slot == SLOT_W'(i)) sel = neg_bank ? stat[i].neg : stat[i].pos;
		end
		rd_value = sat_read(sel);
	end

endmodule

`default_nettype wire

/* sv/tsetlin_clause_vote_feedback_top.sv */
// channel | dir | payload
// --------+-----+---------------------------------------------------------------
// item    | in  | command, features, radical_mask, conservative_mask,
//         |     | literal_index, write_value
// result  | out | clause_output, read_value
//
// one beat per cycle while the result side keeps up: every lane updates its automata in the cycle a beat is taken
// result is registered and shows in the cycle after the item beat
// a new item is taken while the result register is empty or being drained
// reset clears all automata, latched features and the last vote at once
// a stalled result blocks further items until it is taken
`default_nettype none

module tsetlin_clause_vote_feedback_top (
	input wire logic  clk,
	input wire logic  arst_n,
	tcvf_in_if.sink   item,
	tcvf_out_if.source result
);
	import tcvf_pkg::*;

	logic       accept;
	lane_ctrl_t ctrl;
	logic       last_vote_q;
	logic       out_valid_q;
	logic       clause_q;
	wval_t      read_q;
	logic       vote;
	wval_t      rd_value;
	slot_t      slot;
	logic       neg_bank;
	lane_stat_t stat [LITERALS];

	assign item.ready = ~out_valid_q | result.ready;
	assign accept     = item.valid & item.ready;
	assign slot       = item.literal_index[SLOT_W-1:0];
	assign neg_bank   = item.literal_index[IDX_W-1];

	assign ctrl.accept    = accept;
	assign ctrl.cmd       = item.command;
	assign ctrl.last_vote = last_vote_q;
	assign ctrl.wdata     = clamp_write(item.write_value);

	for (genvar i = 0; i < LITERALS; i++) begin : g_lane
		logic wr_hit;
		assign wr_hit = (item.command == CMD_WRITE) && (slot == SLOT_W'(i));

		tcvf_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.feature      (item.features[i]),
			.radical      (item.radical_mask[i]),
			.conservative (item.conservative_mask[i]),
			.wr_pos       (wr_hit & ~neg_bank),
			.wr_neg       (wr_hit & neg_bank),
			.stat         (stat[i])
		);
	end

	tcvf_merge u_merge (
		.stat     (stat),
		.slot     (slot),
		.neg_bank (neg_bank),
		.vote     (vote),
		.rd_value (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_vote_q <= 1'b0;
		end else begin
			if (accept) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (accept && item.command == CMD_VOTE) last_vote_q <= vote;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clause_q <= (item.command == CMD_VOTE) ? vote : last_vote_q;
			read_q   <= (item.command == CMD_READ) ? rd_value : '0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.clause_output = clause_q;
	assign result.read_value    = read_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid && result.clause_output == last_vote_q)
		else $error("result beat missing or clause output differs from last vote");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.command != CMD_READ |=> result.read_value == '0)
		else $error("read value nonzero for a non-read command");

	a_vote_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && item.command == CMD_VOTE) |=> $stable(last_vote_q))
		else $error("last vote changed without a vote beat");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> item.ready)
		else $error("item not ready while result register is empty");

endmodule

`default_nettype wire

/* tb/tsetlin_clause_vote_feedback_top_tb.sv */
`timescale 1ns / 100ps

module tsetlin_clause_vote_feedback_top_tb;
	import tcvf_pkg::*;

	localparam int     CLK_PERIOD   = 8;
	localparam int     RESET_CYCLES = 5;
	localparam int     PHASES       = 4;
	localparam int     PHASE_ITEMS  = 120;
	localparam int     HOLD_CYCLES  = 64;
	localparam int     MAX_GAP      = 20;
	localparam int     DRAIN_CYCLES = 4;
	localparam int     MAX_PRINTS   = 20;
	localparam int     DIR_ROWS     = 24;
	localparam longint TIMEOUT_NS   = 4_000_000;

	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam feat_t ONES = '1;
	localparam feat_t ZERO = '0;
	localparam feat_t EVEN = 64'h5555_5555_5555_5555;

	typedef struct packed {
		logic  vote;
		wval_t rd;
	} clause_res_t;

	localparam clause_res_t RES_IDLE = '0;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		feat_t            feat;
		feat_t            rad;
		feat_t            con;
		idx_t             idx;
		wval_t            wval;
		bit               typed;
		clause_res_t      res;
	} stim_row_t;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd0,   8'sh00, 1'b1, RES_IDLE},
		'{CMD_READ,  ONES, ONES, ONES, 7'd127, 8'shFF, 1'b1, RES_IDLE},
		'{CMD_RSVD5, ONES, ONES, ONES, 7'd64,  8'sh7F, 1'b1, RES_IDLE},
		'{CMD_RSVD7, ZERO, ZERO, ZERO, 7'd63,  8'sh80, 1'b1, RES_IDLE},
		'{CMD_FB2,   ONES, ONES, ONES, 7'd0,   8'sh00, 1'b1, RES_IDLE},
		'{CMD_VOTE,  ONES, ZERO, ZERO, 7'd0,   8'sh00, 1'b1, RES_IDLE},
		'{CMD_VOTE,  ZERO, ONES, ONES, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_WRITE, ZERO, ZERO, ZERO, 7'd0,   8'sh7F, 1'b0, RES_IDLE},
		'{CMD_WRITE, ZERO, ZERO, ZERO, 7'd64,  8'sh80, 1'b0, RES_IDLE},
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd64,  8'sh00, 1'b0, RES_IDLE},
		'{CMD_FB1,   ZERO, ONES, ONES, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_WRITE, ZERO, ZERO, ZERO, 7'd63,  8'sh80, 1'b0, RES_IDLE},
		'{CMD_FB1,   ZERO, ZERO, ONES, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_WRITE, ZERO, ZERO, ZERO, 7'd2,   8'sh7F, 1'b0, RES_IDLE},
		'{CMD_VOTE,  EVEN, ZERO, ZERO, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_FB1,   ZERO, ONES, ZERO, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_FB1,   ZERO, ZERO, ONES, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_FB2,   ZERO, ZERO, ZERO, 7'd0,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_VOTE,  64'h0123_4567_89AB_CDEF, ZERO, ZERO, 7'd0, 8'sh00, 1'b0, RES_IDLE},
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd2,   8'sh00, 1'b0, RES_IDLE},
		'{CMD_RSVD6, ONES, ONES, ONES, 7'd2,   8'sh7F, 1'b0, RES_IDLE},
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd127, 8'sh00, 1'b0, RES_IDLE},
		'{CMD_READ,  ZERO, ZERO, ZERO, 7'd66,  8'sh00, 1'b0, RES_IDLE}
	};

	logic clk = 1'b0;
	logic arst_n;

	tcvf_in_if  item_ch ();
	tcvf_out_if result_ch ();

	tsetlin_clause_vote_feedback_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted clause state
	state_t pos_ta [LITERALS];
	state_t neg_ta [LITERALS];
	feat_t  lat_feat;
	feat_t  pos_excl;
	feat_t  neg_excl;
	logic   last_vote;

	clause_res_t expected_clause_q [$];

	bit          row_typed;
	clause_res_t row_res;
	int          idle_pct;
	int          stall_pct;
	int          hold_req;
	int          err_count;
	int          n_items;
	int          n_results;
	int          n_vote_one;

	function automatic state_t to_state(input longint v);
		if (v > STATE_MAX) v = STATE_MAX;
		if (v < STATE_MIN) v = STATE_MIN;
		return state_t'(v);
	endfunction

	function automatic state_t nudge(input state_t s, input int delta);
		return to_state(longint'(s) + longint'(delta));
	endfunction

	task automatic clause_update(input logic [CMD_W-1:0] cmd, input feat_t feat,
		input feat_t rad, input feat_t con, input idx_t idx, input wval_t wval,
		output clause_res_t res);
		feat_t  pinc;
		feat_t  ninc;
		slot_t  slot;
		longint v;
		int     i;
		res    = RES_IDLE;
		slot   = idx[SLOT_W-1:0];
		pinc   = '0;
		ninc   = '0;
		case (cmd)
			CMD_VOTE: begin
				for (i = 0; i < LITERALS; i++) begin
					pinc[i] = !pos_ta[i][STATE_BITS-1];
					ninc[i] = !neg_ta[i][STATE_BITS-1];
				end
				lat_feat  = feat;
				pos_excl  = ~pinc;
				neg_excl  = ~ninc;
				last_vote = ((pinc & ~feat) == '0) && ((ninc & feat) == '0);
			end
			CMD_FB1: begin
				for (i = 0; i < LITERALS; i++) begin
					if (last_vote) begin
						if (lat_feat[i] && rad[i]) pos_ta[i] = nudge(pos_ta[i], 1);
						if (!lat_feat[i] && con[i]) pos_ta[i] = nudge(pos_ta[i], -1);
						if (lat_feat[i] && con[i]) neg_ta[i] = nudge(neg_ta[i], -1);
						if (!lat_feat[i] && rad[i]) neg_ta[i] = nudge(neg_ta[i], 1);
					end else begin
						if (con[i]) pos_ta[i] = nudge(pos_ta[i], -1);
						if (!rad[i]) neg_ta[i] = nudge(neg_ta[i], -1);
					end
				end
			end
			CMD_FB2: begin
				if (last_vote) begin
					for (i = 0; i < LITERALS; i++) begin
						if (pos_excl[i] && !lat_feat[i]) pos_ta[i] = nudge(pos_ta[i], 1);
						if (neg_excl[i] && lat_feat[i]) neg_ta[i] = nudge(neg_ta[i], 1);
					end
				end
			end
			CMD_WRITE: begin
				if (idx[SLOT_W]) neg_ta[slot] = to_state(longint'(wval));
				else pos_ta[slot] = to_state(longint'(wval));
			end
			CMD_READ: begin
				v = idx[SLOT_W] ? longint'(neg_ta[slot]) : longint'(pos_ta[slot]);
				if (v > WVAL_MAX) v = WVAL_MAX;
				if (v < WVAL_MIN) v = WVAL_MIN;
				res.rd = wval_t'(v);
			end
			default: ;
		endcase
		res.vote = last_vote;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic feat_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic feat_t biased_mask(input int num, input int den);
		feat_t m;
		int    i;
		for (i = 0; i < FEAT_W; i++)
			m[i] = ($urandom_range(0, den - 1) < num);
		return m;
	endfunction

	// features that satisfy as many included literals as possible
	function automatic feat_t agreeable_features();
		feat_t f;
		int    i;
		f = rand_word();
		for (i = 0; i < LITERALS; i++) begin
			if (!pos_ta[i][STATE_BITS-1]) f[i] = 1'b1;
			else if (!neg_ta[i][STATE_BITS-1]) f[i] = 1'b0;
		end
		return f;
	endfunction

	function automatic int pick_gap();
		int g;
		g = 0;
		while (g < MAX_GAP && $urandom_range(0, 99) < idle_pct) g++;
		return g;
	endfunction

	task automatic make_random(output stim_row_t r);
		int roll;
		int spec;
		roll = $urandom_range(0, 99);
		spec = $urandom_range(1, 12);
		if (roll < 25) r.cmd = CMD_VOTE;
		else if (roll < 55) r.cmd = CMD_FB1;
		else if (roll < 70) r.cmd = CMD_FB2;
		else if (roll < 80) r.cmd = CMD_WRITE;
		else if (roll < 95) r.cmd = CMD_READ;
		else r.cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
		r.feat = $urandom_range(0, 1) ? agreeable_features() : rand_word();
		if ($urandom_range(0, 4) == 0) begin
			r.rad = rand_word();
			r.con = rand_word();
		end else begin
			r.rad = biased_mask(spec - 1, spec);
			r.con = biased_mask(1, spec);
		end
		r.idx = idx_t'($urandom_range(0, 127));
		if ($urandom_range(0, 1)) r.wval = wval_t'($urandom_range(0, 9) - 5);
		else r.wval = wval_t'($urandom_range(0, 255));
		r.typed = 1'b0;
		r.res   = RES_IDLE;
	endtask

	task automatic send_item(input stim_row_t r, input int gap);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid             <= 1'b1;
		item_ch.command           <= cmd_t'(r.cmd);
		item_ch.features          <= r.feat;
		item_ch.radical_mask      <= r.rad;
		item_ch.conservative_mask <= r.con;
		item_ch.literal_index     <= r.idx;
		item_ch.write_value       <= r.wval;
		row_typed                 <= r.typed;
		row_res                   <= r.res;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (expected_clause_q.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		clause_res_t got;
		clause_res_t want;
		clause_res_t pred;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.vote = result_ch.clause_output;
				got.rd   = result_ch.read_value;
				n_results++;
				if (got.vote) n_vote_one++;
				if (expected_clause_q.size() == 0) begin
					report_mismatch("result beat with nothing pending, clause", got.vote, 0);
				end else begin
					want = expected_clause_q.pop_front();
					if (got.vote !== want.vote)
						report_mismatch("clause_output", got.vote, want.vote);
					if (got.rd !== want.rd)
						report_mismatch("read_value", longint'(got.rd), longint'(want.rd));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				clause_update(item_ch.command, item_ch.features, item_ch.radical_mask,
					item_ch.conservative_mask, item_ch.literal_index, item_ch.write_value, pred);
				expected_clause_q.push_back(row_typed ? row_res : pred);
				n_items++;
			end
		end
	end

	// result side: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		stim_row_t r;
		int        phase;
		int        k;
		arst_n     = 1'b0;
		err_count  = 0;
		n_items    = 0;
		n_results  = 0;
		n_vote_one = 0;
		idle_pct   = 0;
		last_vote  = 1'b0;
		lat_feat   = '0;
		pos_excl   = '0;
		neg_excl   = '0;
		for (k = 0; k < LITERALS; k++) begin
			pos_ta[k] = '0;
			neg_ta[k] = '0;
		end
		stall_pct                 <= 0;
		hold_req                  <= 0;
		row_typed                 <= 1'b0;
		row_res                   <= RES_IDLE;
		item_ch.valid             <= 1'b0;
		item_ch.command           <= CMD_VOTE;
		item_ch.features          <= '0;
		item_ch.radical_mask      <= '0;
		item_ch.conservative_mask <= '0;
		item_ch.literal_index     <= '0;
		item_ch.write_value       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			send_item(dir_rows[k], 0);
		item_ch.valid <= 1'b0;
		wait_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 47;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 47;
				end
				default: begin
					idle_pct = 8;
					stall_pct <= 8;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// long result hold-off while items keep coming back to back
				if (phase == 0 && k == PHASE_ITEMS / 2) hold_req <= hold_req + 1;
				make_random(r);
				send_item(r, pick_gap());
			end
			item_ch.valid <= 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d directed), %0d results, %0d with clause high",
			n_items, DIR_ROWS, n_results, n_vote_one);
		$display("idling: none, sender 47%%, receiver 47%%, both 8%%; one long result hold-off");
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/tcvf_pkg.sv
sv/tcvf_ifs.sv
sv/tcvf_lane.sv
sv/tcvf_merge.sv
sv/tsetlin_clause_vote_feedback_top.sv
tb/tsetlin_clause_vote_feedback_top_tb.sv
